>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file scl_checker
// clock clk and reset arst_n are taken from the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SCL_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCL_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/scl_pkg.sv
// shared constants, types and keyword matcher function for the command line parser
// no dependencies
`timescale 1ns / 1ps

package scl_pkg;

	localparam int NUM_KEYS = 7;
	localparam int MAX_LINE = 100;
	localparam int LEN_W    = 8;
	localparam int PERIOD_W = 16;
	localparam int CODE_W   = 3;
	localparam int OUT_W    = 24;

	localparam logic [7:0] NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_0  = 8'h30;
	localparam logic [7:0] CHAR_9  = 8'h39;

	localparam logic [2:0] KEY_SCALE_F = 3'd0;
	localparam logic [2:0] KEY_SCALE_C = 3'd1;
	localparam logic [2:0] KEY_PERIOD  = 3'd2;
	localparam logic [2:0] KEY_STOP    = 3'd3;
	localparam logic [2:0] KEY_START   = 3'd4;
	localparam logic [2:0] KEY_LOG     = 3'd5;
	localparam logic [2:0] KEY_OFF     = 3'd6;
	localparam logic [2:0] KEY_NONE    = 3'd7;

	localparam logic [CODE_W-1:0] CMD_SCALE_F = 3'd0;
	localparam logic [CODE_W-1:0] CMD_SCALE_C = 3'd1;
	localparam logic [CODE_W-1:0] CMD_PERIOD  = 3'd2;
	localparam logic [CODE_W-1:0] CMD_STOP    = 3'd3;
	localparam logic [CODE_W-1:0] CMD_START   = 3'd4;
	localparam logic [CODE_W-1:0] CMD_LOG     = 3'd5;
	localparam logic [CODE_W-1:0] CMD_OFF     = 3'd6;
	localparam logic [CODE_W-1:0] CMD_INVALID = 3'd7;

	localparam logic [7:0] KEY_CHR [NUM_KEYS][8] = '{
		'{"S", "C", "A", "L", "E", "=", "F", 8'h00},
		'{"S", "C", "A", "L", "E", "=", "C", 8'h00},
		'{"P", "E", "R", "I", "O", "D", "=", 8'h00},
		'{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00},
		'{"L", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{3'd7, 3'd7, 3'd7, 3'd4, 3'd5, 3'd3, 3'd3};

	typedef struct packed {
		logic [NUM_KEYS-1:0] found;
		logic [LEN_W-1:0]    len;
		logic                pfx_log;
		logic                pfx_period;
		logic                digits_ok;
		logic [PERIOD_W-1:0] acc;
	} scl_line_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              scale_we;
		logic              scale_val;
		logic              period_we;
		logic              stop_we;
		logic              stop_val;
		logic              off;
	} scl_cmd_t;

	// longest keyword prefix that ends the matched text followed by c
	function automatic logic [2:0] kw_advance(input logic [2:0] key, input logic [2:0] p,
			input logic [7:0] c);
		logic [2:0] res;
		logic       hit;
		logic       eq;
		int         len;
		int         pp;
		int         kk;
		int         j;
		len = int'(KEY_LEN[key]);
		pp  = int'(p);
		if (pp >= len) begin
			pp = len - 1;
		end
		res = 3'd0;
		hit = 1'b0;
		for (kk = 7; kk >= 1; kk--) begin
			if (!hit && kk <= pp + 1 && kk <= len) begin
				eq = (KEY_CHR[key][3'(kk - 1)] == c);
				for (j = 0; j < 6; j++) begin
					if (j < kk - 1) begin
						if (KEY_CHR[key][3'(j)] != KEY_CHR[key][3'(pp - kk + 1 + j)]) begin
							eq = 1'b0;
						end
					end
				end
				if (eq) begin
					res = 3'(kk);
					hit = 1'b1;
				end
			end
		end
		return res;
	endfunction

endpackage

>>> rtl/core/sensor_command_line_parser.sv
// Sensor command line parser: takes one byte or button event per transfer and
// reports one result per newline. Depends on scl_pkg, scl_line and scl_cmd.
`timescale 1ns / 1ps

// Each input transfer is registered, then matched and decoded combinationally and
// the result lands in the output register, so one transfer is taken every clock
// while the output is free. Only a newline produces a result: a stalled output
// blocks newlines but not plain bytes or button presses. Configuration writes
// load the period or scale setting at once and should only be issued while the
// block is idle.

module sensor_command_line_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	// command_code[2:0], scale_celsius[3], sample_period[19:4], stopped[20],
	// shutdown_req[21], zero[23:22]
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import scl_pkg::*;

	logic                valid_s1;
	logic                action_s1;
	logic [7:0]          byte_s1;
	logic                nl_s1;
	logic                go_s1;
	logic                out_free;

	logic                scale_q;
	logic [PERIOD_W-1:0] period_q;
	logic                stop_q;
	logic                shutdown_q;

	logic                scale_n;
	logic [PERIOD_W-1:0] period_n;
	logic                stop_n;
	logic                shutdown_n;

	logic                out_valid_q;
	logic [CODE_W-1:0]   out_code_q;
	logic                out_scale_q;
	logic [PERIOD_W-1:0] out_period_q;
	logic                out_stop_q;
	logic                out_shutdown_q;

	scl_line_t line;
	scl_cmd_t  cmd;

	assign nl_s1    = valid_s1 && !action_s1 && (byte_s1 == NEWLINE);
	assign out_free = !out_valid_q || m_tready;
	assign go_s1    = valid_s1 && (!nl_s1 || out_free);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	scl_line u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (go_s1 && !action_s1 && !nl_s1),
		.clr     (go_s1 && nl_s1),
		.rx_byte (byte_s1),
		.line    (line)
	);

	scl_cmd u_cmd (
		.line (line),
		.cmd  (cmd)
	);

	assign scale_n    = cmd.scale_we ? cmd.scale_val : scale_q;
	assign period_n   = cmd.period_we ? line.acc : period_q;
	assign stop_n     = cmd.stop_we ? cmd.stop_val : stop_q;
	assign shutdown_n = shutdown_q || cmd.off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= 1'b0;
			period_q   <= PERIOD_W'(1);
			stop_q     <= 1'b0;
			shutdown_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index) begin
				scale_q <= cfg_data[0];
			end else begin
				period_q <= cfg_data;
			end
		end else if (go_s1 && action_s1) begin
			shutdown_q <= 1'b1;
		end else if (go_s1 && nl_s1) begin
			scale_q    <= scale_n;
			period_q   <= period_n;
			stop_q     <= stop_n;
			shutdown_q <= shutdown_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && nl_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && nl_s1) begin
			out_code_q     <= cmd.code;
			out_scale_q    <= scale_n;
			out_period_q   <= period_n;
			out_stop_q     <= stop_n;
			out_shutdown_q <= shutdown_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_shutdown_q, out_stop_q, out_period_q, out_scale_q, out_code_q};

endmodule

>>> rtl/core/scl_line.sv
// per-line state: keyword matchers, line length, prefix flags and period digits
// depends on scl_pkg
`timescale 1ns / 1ps

module scl_line (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              clr,
	input  logic [7:0]        rx_byte,
	output scl_pkg::scl_line_t line
);
	import scl_pkg::*;

	logic [2:0]          prog_q [NUM_KEYS];
	logic [2:0]          prog_n [NUM_KEYS];
	logic [NUM_KEYS-1:0] hit;
	logic [NUM_KEYS-1:0] found_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    newlen;
	logic                pfx_log_q;
	logic                pfx_period_q;
	logic                digits_ok_q;
	logic [PERIOD_W-1:0] acc_q;
	logic [19:0]         acc10;
	logic [PERIOD_W-1:0] acc_sat;
	logic                is_digit;

	for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
		assign prog_n[i] = kw_advance(3'(i), prog_q[i], rx_byte);
		assign hit[i]    = (prog_n[i] >= KEY_LEN[i]);
	end

	assign newlen   = (len_q < LEN_W'(MAX_LINE)) ? len_q + LEN_W'(1) : LEN_W'(MAX_LINE);
	assign is_digit = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
	assign acc10    = 20'({acc_q, 3'b000}) + 20'({acc_q, 1'b0}) + 20'(rx_byte[3:0]);
	assign acc_sat  = (acc10[19:16] != 4'd0) ? {PERIOD_W{1'b1}} : acc10[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				prog_q[i] <= 3'd0;
			end
			found_q      <= '0;
			len_q        <= '0;
			pfx_log_q    <= 1'b0;
			pfx_period_q <= 1'b0;
			digits_ok_q  <= 1'b1;
			acc_q        <= '0;
		end else if (clr) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				prog_q[i] <= 3'd0;
			end
			found_q      <= '0;
			len_q        <= '0;
			pfx_log_q    <= 1'b0;
			pfx_period_q <= 1'b0;
			digits_ok_q  <= 1'b1;
			acc_q        <= '0;
		end else if (step) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				if (!found_q[i]) begin
					prog_q[i] <= prog_n[i];
					if (hit[i]) begin
						found_q[i] <= 1'b1;
					end
				end
			end
			if (!found_q[KEY_LOG] && hit[KEY_LOG] && newlen == LEN_W'(3)) begin
				pfx_log_q <= 1'b1;
			end
			if (!found_q[KEY_PERIOD] && hit[KEY_PERIOD] && newlen == LEN_W'(7)) begin
				pfx_period_q <= 1'b1;
			end
			if (len_q >= LEN_W'(7)) begin
				if (is_digit) begin
					acc_q <= acc_sat;
				end else begin
					digits_ok_q <= 1'b0;
				end
			end
			len_q <= newlen;
		end
	end

	assign line.found      = found_q;
	assign line.len        = len_q;
	assign line.pfx_log    = pfx_log_q;
	assign line.pfx_period = pfx_period_q;
	assign line.digits_ok  = digits_ok_q;
	assign line.acc        = acc_q;

endmodule

>>> rtl/core/scl_cmd.sv
// end-of-line decode: picks the keyword by priority and validates the line
// depends on scl_pkg
`timescale 1ns / 1ps

module scl_cmd (
	input  scl_pkg::scl_line_t line,
	output scl_pkg::scl_cmd_t  cmd
);
	import scl_pkg::*;

	logic [2:0] pick;
	logic       len_ok;

	always_comb begin
		pick = KEY_NONE;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (line.found[i]) begin
				pick = 3'(i);
			end
		end
	end

	assign len_ok = (line.len <= LEN_W'(MAX_LINE - 2));

	always_comb begin
		cmd = '0;
		cmd.code = CMD_INVALID;
		if (len_ok) begin
			unique case (pick)
				KEY_SCALE_F: begin
					if (line.len == LEN_W'(7)) begin
						cmd.code      = CMD_SCALE_F;
						cmd.scale_we  = 1'b1;
						cmd.scale_val = 1'b0;
					end
				end
				KEY_SCALE_C: begin
					if (line.len == LEN_W'(7)) begin
						cmd.code      = CMD_SCALE_C;
						cmd.scale_we  = 1'b1;
						cmd.scale_val = 1'b1;
					end
				end
				KEY_PERIOD: begin
					if (line.pfx_period && line.digits_ok) begin
						cmd.code      = CMD_PERIOD;
						cmd.period_we = 1'b1;
					end
				end
				KEY_STOP: begin
					if (line.len == LEN_W'(4)) begin
						cmd.code     = CMD_STOP;
						cmd.stop_we  = 1'b1;
						cmd.stop_val = 1'b1;
					end
				end
				KEY_START: begin
					if (line.len == LEN_W'(5)) begin
						cmd.code     = CMD_START;
						cmd.stop_we  = 1'b1;
						cmd.stop_val = 1'b0;
					end
				end
				KEY_LOG: begin
					if (line.pfx_log) begin
						cmd.code = CMD_LOG;
					end
				end
				KEY_OFF: begin
					if (line.len == LEN_W'(3)) begin
						cmd.code = CMD_OFF;
						cmd.off  = 1'b1;
					end
				end
				default: begin
					cmd.code = CMD_INVALID;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/scl_checker.sv
// port-level checks for the command line parser, bound to the top level
// depends on scl_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic [15:0] cfg_data
);
	import scl_pkg::*;

	`SCL_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`SCL_ASSERT_NOW(a_off_sets_shutdown, m_tvalid && m_tdata[2:0] == CMD_OFF, m_tdata[21], "off without shutdown")
	`SCL_ASSERT_NOW(a_stop_flag, m_tvalid && m_tdata[2:0] == CMD_STOP, m_tdata[20], "stop not reflected")
	`SCL_ASSERT_NOW(a_start_flag, m_tvalid && m_tdata[2:0] == CMD_START, !m_tdata[20], "start not reflected")
	`SCL_ASSERT_NOW(a_scale_c, m_tvalid && m_tdata[2:0] == CMD_SCALE_C, m_tdata[3], "celsius not reflected")

endmodule

bind sensor_command_line_parser scl_checker u_scl_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for sensor_command_line_parser: directed command lines,
// then random lines under config changes, each result checked by a line predictor
// or a listed directed result. Depends on scl_pkg and sensor_command_line_parser.
`timescale 1ns / 1ps

module tb_top;
	import scl_pkg::*;

	localparam logic REG_DEFAULT_PERIOD = 1'b0;
	localparam logic REG_DEFAULT_SCALE  = 1'b1;
	localparam int   NUM_PHASES         = 4;
	localparam int   PHASE_TRANSFERS    = 310;
	localparam int   SETTLE_CYCLES      = 4;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam string ALPHABET          = "SCALEFPRIODTGN=C0123456789 x";

	typedef struct packed {
		logic [1:0]  spare;
		logic        shutdown_req;
		logic        stopped;
		logic [15:0] sample_period;
		logic        scale_celsius;
		logic [2:0]  command_code;
	} line_result_t;

	typedef struct {
		string       text;
		logic [7:0]  fill;
		int          fill_n;
		bit          press;
		bit          typed;
		logic [2:0]  code;
		logic        scale;
		logic [15:0] period;
		logic        stop;
		logic        shut;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	sensor_command_line_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	string kw_name [NUM_KEYS] = '{"SCALE=F", "SCALE=C", "PERIOD=", "STOP", "START", "LOG", "OFF"};

	stim_row_t directed_rows [] = '{
		'{"",             8'h00, 0,   1'b0, 1'b1, CMD_INVALID, 1'b0, 16'd1,     1'b0, 1'b0},
		'{"HELLO",        8'h00, 0,   1'b0, 1'b1, CMD_INVALID, 1'b0, 16'd1,     1'b0, 1'b0},
		'{"SCALE=C",      8'h00, 0,   1'b0, 1'b1, CMD_SCALE_C, 1'b1, 16'd1,     1'b0, 1'b0},
		'{"SCALE=F",      8'h00, 0,   1'b0, 1'b1, CMD_SCALE_F, 1'b0, 16'd1,     1'b0, 1'b0},
		'{"PERIOD=",      8'h00, 0,   1'b0, 1'b1, CMD_PERIOD,  1'b0, 16'd0,     1'b0, 1'b0},
		'{"PERIOD=99999", 8'h00, 0,   1'b0, 1'b1, CMD_PERIOD,  1'b0, 16'd65535, 1'b0, 1'b0},
		'{"",             8'hFF, 250, 1'b0, 1'b1, CMD_INVALID, 1'b0, 16'd65535, 1'b0, 1'b0},
		'{"PERIOD=42",    8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"STOP",         8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"START",        8'h00, 0,   1'b1, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"LOG EXTRA",    8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"SCALE=FX",     8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"XSTOP",        8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"STOP LOG",     8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"PERIOD=12A",   8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"PERIOD=",      "9",   91,  1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"PERIOD=",      "1",   92,  1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"STOP",         8'h0D, 1,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"LOG",          8'h00, 1,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"",             8'h00, 1,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"SSCALE=C",     8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"OFF",          8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"SCALE=C",      8'h00, 0,   1'b1, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"LOGOFF",       8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0},
		'{"OFFSTOP",      8'h00, 0,   1'b0, 1'b0, CMD_INVALID, 1'b0, 16'd0,     1'b0, 1'b0}
	};

	// parser state mirror
	int unsigned kw_prog [NUM_KEYS];
	bit          kw_seen [NUM_KEYS];
	int unsigned line_bytes;
	bit          starts_log;
	bit          starts_period;
	bit          only_digits;
	int unsigned period_value;
	logic        cur_scale;
	logic [15:0] cur_period;
	logic        cur_stopped;
	logic        cur_shutdown;
	logic [15:0] reg_default_period;
	logic        reg_default_scale;

	line_result_t expected_results [$];
	int           mismatch_count;
	int           transfers_sent;
	int unsigned  cycle_count;
	bit           calm;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_wait();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic int unsigned next_match(int unsigned key, int unsigned matched,
			logic [7:0] ch);
		string       t;
		int unsigned n;
		int unsigned p;
		int unsigned k;
		int unsigned j;
		bit          same;
		t = kw_name[key];
		n = t.len();
		p = matched;
		k = (p + 1 < n) ? p + 1 : n;
		if (p >= n) begin
			p = n - 1;
		end
		for (; k > 0; k--) begin
			if (t[k-1] != ch || k - 1 > p) begin
				continue;
			end
			same = 1'b1;
			for (j = 0; j + 1 < k; j++) begin
				if (t[j] != t[p - (k - 1) + j]) begin
					same = 1'b0;
				end
			end
			if (same) begin
				return k;
			end
		end
		return 0;
	endfunction

	function automatic void clear_line_state();
		for (int i = 0; i < NUM_KEYS; i++) begin
			kw_prog[i] = 0;
			kw_seen[i] = 1'b0;
		end
		line_bytes    = 0;
		starts_log    = 1'b0;
		starts_period = 1'b0;
		only_digits   = 1'b1;
		period_value  = 0;
	endfunction

	function automatic void parse_byte(logic [7:0] ch);
		int unsigned newlen;
		int unsigned v;
		newlen = (line_bytes < MAX_LINE) ? line_bytes + 1 : MAX_LINE;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (!kw_seen[i]) begin
				kw_prog[i] = next_match(i, kw_prog[i] & 7, ch);
				if (kw_prog[i] >= kw_name[i].len()) begin
					kw_seen[i] = 1'b1;
					if (i == KEY_LOG && newlen == 3) begin
						starts_log = 1'b1;
					end
					if (i == KEY_PERIOD && newlen == 7) begin
						starts_period = 1'b1;
					end
				end
			end
		end
		if (line_bytes >= 7) begin
			if (ch >= CHAR_0 && ch <= CHAR_9) begin
				v = period_value * 10 + (ch - CHAR_0);
				period_value = (v > 16'hFFFF) ? 16'hFFFF : v;
			end else begin
				only_digits = 1'b0;
			end
		end
		line_bytes = newlen;
	endfunction

	function automatic line_result_t close_line();
		line_result_t res;
		int           pick;
		logic [2:0]   code;
		pick = NUM_KEYS;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (kw_seen[i]) begin
				pick = i;
			end
		end
		code = CMD_INVALID;
		if (line_bytes <= MAX_LINE - 2) begin
			case (pick)
				KEY_SCALE_F: if (line_bytes == 7) begin
					cur_scale = 1'b0;
					code = CMD_SCALE_F;
				end
				KEY_SCALE_C: if (line_bytes == 7) begin
					cur_scale = 1'b1;
					code = CMD_SCALE_C;
				end
				KEY_PERIOD: if (starts_period && only_digits) begin
					cur_period = period_value[15:0];
					code = CMD_PERIOD;
				end
				KEY_STOP: if (line_bytes == 4) begin
					cur_stopped = 1'b1;
					code = CMD_STOP;
				end
				KEY_START: if (line_bytes == 5) begin
					cur_stopped = 1'b0;
					code = CMD_START;
				end
				KEY_LOG: if (starts_log) begin
					code = CMD_LOG;
				end
				KEY_OFF: if (line_bytes == 3) begin
					cur_shutdown = 1'b1;
					code = CMD_OFF;
				end
				default: begin
				end
			endcase
		end
		clear_line_state();
		res = '{2'b00, cur_shutdown, cur_stopped, cur_period, cur_scale, code};
		return res;
	endfunction

	task automatic send_transfer(input bit press, input logic [7:0] ch, input bit typed,
			input line_result_t typed_res);
		int gap;
		gap = pick_wait();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= press;
		s_tdata  <= ch;
		do @(posedge clk); while (!s_tready);
		transfers_sent++;
		if (press) begin
			cur_shutdown = 1'b1;
		end else if (ch == NEWLINE) begin
			if (typed) begin
				void'(close_line());
				expected_results.push_back(typed_res);
			end else begin
				expected_results.push_back(close_line());
			end
		end else begin
			parse_byte(ch);
		end
	endtask

	task automatic send_plain(input logic [7:0] ch);
		send_transfer(1'b0, ch, 1'b0, '0);
	endtask

	task automatic press_button();
		send_transfer(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_DEFAULT_PERIOD) begin
			reg_default_period = val;
			cur_period = val;
		end else begin
			reg_default_scale = val[0];
			cur_scale = val[0];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] any_char(bit from_alphabet);
		logic [7:0] b;
		do begin
			b = from_alphabet ? ALPHABET[$urandom_range(0, ALPHABET.len() - 1)] :
				8'($urandom_range(0, 255));
		end while (b == NEWLINE);
		return b;
	endfunction

	function automatic void push_word(ref logic [7:0] q[$], input string w);
		for (int i = 0; i < w.len(); i++) begin
			q.push_back(w[i]);
		end
	endfunction

	function automatic void push_digits(ref logic [7:0] q[$], input int n);
		repeat (n) q.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
	endfunction

	// mostly well-formed commands, the rest damaged or noise
	task automatic compose_line(ref logic [7:0] q[$]);
		int kind;
		int key;
		int pos;
		int n;
		q.delete();
		kind = $urandom_range(0, 15);
		key  = $urandom_range(0, NUM_KEYS - 1);
		case (kind)
			0, 1, 2, 3, 4, 5, 6, 14, 15: begin
				if (kind < NUM_KEYS) begin
					key = kind;
				end
				push_word(q, kw_name[key]);
				if (key == KEY_PERIOD) begin
					n = ($urandom_range(0, 19) == 0) ? $urandom_range(80, 100) :
						$urandom_range(0, 6);
					push_digits(q, n);
				end else if (key == KEY_LOG) begin
					repeat ($urandom_range(0, 8)) q.push_back(any_char($urandom_range(0, 1)));
				end
			end
			7, 8: begin
				push_word(q, kw_name[key]);
				pos = $urandom_range(0, q.size() - 1);
				case ($urandom_range(0, 2))
					0: q.insert(pos, any_char($urandom_range(0, 1)));
					1: q.delete(pos);
					default: q[pos] = any_char(1'b1);
				endcase
			end
			9: begin
				repeat ($urandom_range(0, 3)) q.push_back(any_char(1'b1));
				push_word(q, kw_name[key]);
				repeat ($urandom_range(0, 3)) q.push_back(any_char(1'b1));
			end
			10: begin
				push_word(q, kw_name[key]);
				push_word(q, kw_name[$urandom_range(0, NUM_KEYS - 1)]);
			end
			11: begin
				repeat ($urandom_range(0, 20)) q.push_back(any_char($urandom_range(0, 1)));
			end
			12: begin
				if ($urandom_range(0, 1)) begin
					push_word(q, kw_name[KEY_PERIOD]);
				end
				repeat ($urandom_range(88, 120)) q.push_back(any_char(1'b1));
			end
			default: begin
				push_word(q, kw_name[KEY_PERIOD]);
				push_digits(q, $urandom_range(0, 4));
				q.push_back(any_char(1'b1));
				push_digits(q, $urandom_range(0, 3));
			end
		endcase
	endtask

	task automatic run_random(input int quota);
		logic [7:0] line_q [$];
		int         stop_at;
		stop_at = transfers_sent + quota;
		while (transfers_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				calm = !calm;
			end
			if ($urandom_range(0, 59) == 0) begin
				drain();
			end
			compose_line(line_q);
			foreach (line_q[i]) begin
				if ($urandom_range(0, 39) == 0) begin
					press_button();
				end
				send_plain(line_q[i]);
			end
			send_plain(NEWLINE);
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		line_result_t got;
		line_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("command_code", want.command_code, got.command_code);
				compare_field("scale_celsius", want.scale_celsius, got.scale_celsius);
				compare_field("sample_period", want.sample_period, got.sample_period);
				compare_field("stopped", want.stopped, got.stopped);
				compare_field("shutdown_req", want.shutdown_req, got.shutdown_req);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sensor_command_line_parser: mismatch");
			$finish;
		end
	end

	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = pick_wait();
			repeat (n) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		logic [15:0]  phase_period [NUM_PHASES];
		logic [15:0]  phase_scale [NUM_PHASES];
		line_result_t typed_res;
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = 8'h00;
		s_tuser        = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_DEFAULT_PERIOD;
		cfg_data       = 16'h0000;
		mismatch_count = 0;
		transfers_sent = 0;
		cycle_count    = 0;
		calm           = 1'b0;

		reg_default_period = 16'd1;
		reg_default_scale  = 1'b0;
		cur_period         = reg_default_period;
		cur_scale          = reg_default_scale;
		cur_stopped        = 1'b0;
		cur_shutdown       = 1'b0;
		clear_line_state();

		phase_period = '{16'd0, 16'hFFFF, 16'($urandom), 16'($urandom_range(1, 300))};
		phase_scale  = '{16'h0001, 16'h0000, 16'($urandom), 16'($urandom) | 16'h0001};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].press) begin
				press_button();
			end
			for (int j = 0; j < directed_rows[r].text.len(); j++) begin
				send_plain(directed_rows[r].text[j]);
			end
			repeat (directed_rows[r].fill_n) send_plain(directed_rows[r].fill);
			typed_res = '{2'b00, directed_rows[r].shut, directed_rows[r].stop,
				directed_rows[r].period, directed_rows[r].scale, directed_rows[r].code};
			send_transfer(1'b0, NEWLINE, directed_rows[r].typed, typed_res);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			write_reg(REG_DEFAULT_PERIOD, phase_period[p]);
			write_reg(REG_DEFAULT_SCALE, phase_scale[p]);
			run_random(PHASE_TRANSFERS);
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("sensor_command_line_parser: match");
		end else begin
			$display("sensor_command_line_parser: mismatch");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/scl_pkg.sv
rtl/core/scl_line.sv
rtl/core/scl_cmd.sv
rtl/core/sensor_command_line_parser.sv
rtl/core/scl_checker.sv
test/tb_top.sv
